// File: rtl/lav_pkg.sv
// Shared widths, step counts and the axis index type for the view-matrix builder.
// Used by lav_norm and look_at_view_matrix_core; depends on nothing.
package lav_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned DiffW     = CoordW + 1;
  localparam int unsigned UnitW     = 32;
  localparam int unsigned VecW      = 64;
  localparam int unsigned ShSteps   = $clog2(VecW);
  localparam int unsigned ScW       = 31;
  localparam int unsigned SqW       = 2 * ScW;
  localparam int unsigned SumW      = 64;
  localparam int unsigned RemW      = SumW + 1;
  localparam int unsigned QuoW      = SqW + 1;
  localparam int unsigned DivSteps  = QuoW;
  localparam int unsigned RootW     = 64;
  localparam int unsigned RootSteps = 32;
  localparam int unsigned DotW      = 66;
  localparam int unsigned RndPos    = 30;
  localparam int unsigned ShiftW    = 34;

  typedef enum logic [1:0] {
    AxRight  = 2'd0,
    AxUpward = 2'd1,
    AxDir    = 2'd2
  } axis_e;

endpackage

// File: rtl/lav_norm.sv
// Pipelined vector normalizer: scales a 64-bit signed 3-vector to unit length in Q1.30.
// Uses lav_pkg widths; leading-one shift, squares, bit-serial divide and square root.
module lav_norm #(
  parameter int unsigned SideW = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic [2:0][lav_pkg::VecW-1:0]         vec_i,
  input  logic [SideW-1:0]                      side_i,
  output logic                                  valid_o,
  output logic [2:0][lav_pkg::UnitW-1:0]        unit_o,
  output logic                                  zero_o,
  output logic [SideW-1:0]                      side_o
);

  localparam int unsigned VecW      = lav_pkg::VecW;
  localparam int unsigned ShSteps   = lav_pkg::ShSteps;
  localparam int unsigned ScW       = lav_pkg::ScW;
  localparam int unsigned SqW       = lav_pkg::SqW;
  localparam int unsigned SumW      = lav_pkg::SumW;
  localparam int unsigned RemW      = lav_pkg::RemW;
  localparam int unsigned QuoW      = lav_pkg::QuoW;
  localparam int unsigned DivSteps  = lav_pkg::DivSteps;
  localparam int unsigned RootW     = lav_pkg::RootW;
  localparam int unsigned RootSteps = lav_pkg::RootSteps;
  localparam int unsigned UnitW     = lav_pkg::UnitW;
  localparam int unsigned TagW      = SideW + 4;

  logic [2:0]                 sgn_in;
  logic [2:0][VecW-1:0]       mag_in;
  logic [TagW-1:0]            tag_in;

  logic [2:0][VecW-1:0]       sh_q  [ShSteps+1];
  logic [TagW-1:0]            sht_q [ShSteps+1];
  logic [ShSteps:0]           shv_q;
  logic [2:0][VecW-1:0]       sh_d  [ShSteps];
  logic [VecW-1:0]            orv   [ShSteps];

  logic [2:0][SqW-1:0]        sq_d, sq_q;
  logic [TagW-1:0]            sqt_q;
  logic                       sqv_q;

  logic [SumW-1:0]            sm_q;
  logic [2:0][SqW-1:0]        smsq_q;
  logic [TagW-1:0]            smt_q;
  logic                       smv_q;

  logic [2:0][RemW-1:0]       rem_in [DivSteps];
  logic [2:0][QuoW-1:0]       quo_in [DivSteps];
  logic [SumW-1:0]            dvs_in [DivSteps];
  logic [TagW-1:0]            dt_in  [DivSteps];
  logic [2:0][RemW-1:0]       rem_d  [DivSteps];
  logic [2:0][QuoW-1:0]       quo_d  [DivSteps];
  logic [2:0][RemW-1:0]       rem_q  [DivSteps];
  logic [2:0][QuoW-1:0]       quo_q  [DivSteps];
  logic [SumW-1:0]            dvs_q  [DivSteps];
  logic [TagW-1:0]            dt_q   [DivSteps];
  logic [DivSteps-1:0]        dv_q;

  logic [2:0][RootW-1:0]      op_in  [RootSteps];
  logic [2:0][RootW-1:0]      rt_in  [RootSteps];
  logic [TagW-1:0]            rtt_in [RootSteps];
  logic [2:0][RootW-1:0]      op_d   [RootSteps];
  logic [2:0][RootW-1:0]      rt_d   [RootSteps];
  logic [2:0][RootW-1:0]      op_q   [RootSteps];
  logic [2:0][RootW-1:0]      rt_q   [RootSteps];
  logic [TagW-1:0]            rtt_q  [RootSteps];
  logic [RootSteps-1:0]       rtv_q;

  logic [2:0][UnitW-1:0]      unit_d, unit_q;
  logic [TagW-1:0]            out_tag_q;
  logic                       out_vld_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sgn_in[j] = vec_i[j][VecW-1];
      mag_in[j] = sgn_in[j] ? (~vec_i[j] + VecW'(1)) : vec_i[j];
    end
    tag_in = {(vec_i == '0), sgn_in, side_i};
  end

  always_comb begin
    for (int k = 0; k < ShSteps; k++) begin
      orv[k]  = sh_q[k][0] | sh_q[k][1] | sh_q[k][2];
      sh_d[k] = sh_q[k];
      if ((orv[k] >> (VecW - ((VecW / 2) >> k))) == '0) begin
        for (int j = 0; j < 3; j++) begin
          sh_d[k][j] = sh_q[k][j] << ((VecW / 2) >> k);
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sq_d[j] = SqW'(sh_q[ShSteps][j][VecW-1 -: ScW]) * SqW'(sh_q[ShSteps][j][VecW-1 -: ScW]);
    end
  end

  always_comb begin
    for (int k = 0; k < DivSteps; k++) begin
      if (k == 0) begin
        for (int j = 0; j < 3; j++) begin
          rem_in[k][j] = RemW'(smsq_q[j]);
        end
        quo_in[k] = '0;
        dvs_in[k] = sm_q;
        dt_in[k]  = smt_q;
      end else begin
        for (int j = 0; j < 3; j++) begin
          rem_in[k][j] = rem_q[k-1][j] << 1;
        end
        quo_in[k] = quo_q[k-1];
        dvs_in[k] = dvs_q[k-1];
        dt_in[k]  = dt_q[k-1];
      end
      for (int j = 0; j < 3; j++) begin
        if (rem_in[k][j] >= RemW'(dvs_in[k])) begin
          rem_d[k][j] = rem_in[k][j] - RemW'(dvs_in[k]);
          quo_d[k][j] = {quo_in[k][j][QuoW-2:0], 1'b1};
        end else begin
          rem_d[k][j] = rem_in[k][j];
          quo_d[k][j] = {quo_in[k][j][QuoW-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < RootSteps; k++) begin
      if (k == 0) begin
        for (int j = 0; j < 3; j++) begin
          op_in[k][j] = RootW'(quo_q[DivSteps-1][j]);
        end
        rt_in[k]  = '0;
        rtt_in[k] = dt_q[DivSteps-1];
      end else begin
        op_in[k]  = op_q[k-1];
        rt_in[k]  = rt_q[k-1];
        rtt_in[k] = rtt_q[k-1];
      end
      for (int j = 0; j < 3; j++) begin
        if (op_in[k][j] >= rt_in[k][j] + (RootW'(1) << (RootW - 2 - 2 * k))) begin
          op_d[k][j] = op_in[k][j] - (rt_in[k][j] + (RootW'(1) << (RootW - 2 - 2 * k)));
          rt_d[k][j] = (rt_in[k][j] >> 1) + (RootW'(1) << (RootW - 2 - 2 * k));
        end else begin
          op_d[k][j] = op_in[k][j];
          rt_d[k][j] = rt_in[k][j] >> 1;
        end
      end
    end
  end

  always_comb begin
    logic [RootW-1:0] rr;
    logic [UnitW-1:0] uu;
    for (int j = 0; j < 3; j++) begin
      rr = rt_q[RootSteps-1][j] + RootW'(1);
      uu = UnitW'(rr[ScW:1]);
      if (rtt_q[RootSteps-1][SideW + j]) begin
        uu = UnitW'(0) - uu;
      end
      if (rtt_q[RootSteps-1][TagW-1]) begin
        uu = '0;
      end
      unit_d[j] = uu;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shv_q     <= '0;
      sqv_q     <= 1'b0;
      smv_q     <= 1'b0;
      dv_q      <= '0;
      rtv_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      shv_q     <= {shv_q[ShSteps-1:0], valid_i};
      sqv_q     <= shv_q[ShSteps];
      smv_q     <= sqv_q;
      dv_q      <= {dv_q[DivSteps-2:0], smv_q};
      rtv_q     <= {rtv_q[RootSteps-2:0], dv_q[DivSteps-1]};
      out_vld_q <= rtv_q[RootSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sh_q[0]  <= mag_in;
      sht_q[0] <= tag_in;
      for (int k = 0; k < ShSteps; k++) begin
        sh_q[k+1]  <= sh_d[k];
        sht_q[k+1] <= sht_q[k];
      end
      sq_q   <= sq_d;
      sqt_q  <= sht_q[ShSteps];
      sm_q   <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
      smsq_q <= sq_q;
      smt_q  <= sqt_q;
      for (int k = 0; k < DivSteps; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        dvs_q[k] <= dvs_in[k];
        dt_q[k]  <= dt_in[k];
      end
      for (int k = 0; k < RootSteps; k++) begin
        op_q[k]  <= op_d[k];
        rt_q[k]  <= rt_d[k];
        rtt_q[k] <= rtt_in[k];
      end
      unit_q    <= unit_d;
      out_tag_q <= rtt_q[RootSteps-1];
    end
  end

  assign valid_o = out_vld_q;
  assign unit_o  = unit_q;
  assign zero_o  = out_tag_q[TagW-1];
  assign side_o  = out_tag_q[SideW-1:0];

endmodule

// File: rtl/look_at_view_matrix_core.sv
// Top level of the camera view-matrix builder: three normalizers, two cross products,
// translation and the result sequencer. Depends on lav_pkg and lav_norm.
//
// Takes eye, target and up in signed Q16.16 and returns three result transactions per
// input, in the order right, upward, viewing direction, each with its unit axis in Q1.30
// and the translation -dot(axis, eye) in Q16.16. The datapath is a pipeline (three 105-stage
// normalizers, each built from a leading-one shifter, a one-bit-per-stage divider and a
// one-bit-per-stage square root) and takes a new input in any cycle in which it is not
// stalled; the first result of an input appears once the input has passed every stage and
// has been loaded into the output register. The single result port, delivering three
// results per input, limits the sustained input rate. The whole pipeline stalls only
// while its last stage is full and the output register still holds results not yet taken.
module look_at_view_matrix_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [lav_pkg::CoordW-1:0]          eye_x_i,
  input  logic [lav_pkg::CoordW-1:0]          eye_y_i,
  input  logic [lav_pkg::CoordW-1:0]          eye_z_i,
  input  logic [lav_pkg::CoordW-1:0]          aim_x_i,
  input  logic [lav_pkg::CoordW-1:0]          aim_y_i,
  input  logic [lav_pkg::CoordW-1:0]          aim_z_i,
  input  logic [lav_pkg::CoordW-1:0]          up_x_i,
  input  logic [lav_pkg::CoordW-1:0]          up_y_i,
  input  logic [lav_pkg::CoordW-1:0]          up_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [lav_pkg::UnitW-1:0]           axis_x_o,
  output logic [lav_pkg::UnitW-1:0]           axis_y_o,
  output logic [lav_pkg::UnitW-1:0]           axis_z_o,
  output logic [lav_pkg::ShiftW-1:0]          shift_o,
  output logic [1:0]                          axis_index_o,
  output logic                                last_o,
  output logic                                degenerate_o
);

  localparam int unsigned CoordW = lav_pkg::CoordW;
  localparam int unsigned DiffW  = lav_pkg::DiffW;
  localparam int unsigned UnitW  = lav_pkg::UnitW;
  localparam int unsigned VecW   = lav_pkg::VecW;
  localparam int unsigned DotW   = lav_pkg::DotW;
  localparam int unsigned RndPos = lav_pkg::RndPos;
  localparam int unsigned ShiftW = lav_pkg::ShiftW;
  localparam int unsigned Side1W = 6 * CoordW;
  localparam int unsigned Side2W = 6 * CoordW + 1;
  localparam int unsigned Side3W = 9 * CoordW + 1;

  function automatic logic [VecW-1:0] smul(input logic [UnitW-1:0] a,
                                           input logic [UnitW-1:0] b);
    return VecW'(signed'(a)) * VecW'(signed'(b));
  endfunction

  function automatic logic [5:0][VecW-1:0] cross_prod(input logic [2:0][UnitW-1:0] a,
                                                      input logic [2:0][UnitW-1:0] b);
    logic [5:0][VecW-1:0] p;
    p[0] = smul(a[1], b[2]);
    p[1] = smul(a[2], b[1]);
    p[2] = smul(a[2], b[0]);
    p[3] = smul(a[0], b[2]);
    p[4] = smul(a[0], b[1]);
    p[5] = smul(a[1], b[0]);
    return p;
  endfunction

  logic en;
  logic take;
  logic load;

  logic [2:0][CoordW-1:0] eye_in, aim_in, up_in;

  logic                   p0v_q;
  logic [2:0][CoordW-1:0] p0_eye_q, p0_up_q;
  logic [2:0][DiffW-1:0]  p0_d_q;
  logic [2:0][VecW-1:0]   n1_vec;

  logic                   n1_v, n1_z;
  logic [2:0][UnitW-1:0]  n1_dir;
  logic [Side1W-1:0]      n1_side;
  logic [2:0][CoordW-1:0] n1_eye, n1_up;

  logic                   c1av_q, c1a_z_q;
  logic [5:0][VecW-1:0]   c1a_p_q;
  logic [2:0][CoordW-1:0] c1a_eye_q;
  logic [2:0][UnitW-1:0]  c1a_dir_q;
  logic                   c1bv_q, c1b_z_q;
  logic [2:0][VecW-1:0]   c1b_v_q;
  logic [2:0][CoordW-1:0] c1b_eye_q;
  logic [2:0][UnitW-1:0]  c1b_dir_q;

  logic                   n2_v, n2_z, n2_z1;
  logic [2:0][UnitW-1:0]  n2_right, n2_dir;
  logic [Side2W-1:0]      n2_side;
  logic [2:0][CoordW-1:0] n2_eye;

  logic                   c2av_q, c2a_z_q;
  logic [5:0][VecW-1:0]   c2a_p_q;
  logic [2:0][CoordW-1:0] c2a_eye_q;
  logic [2:0][UnitW-1:0]  c2a_dir_q, c2a_right_q;
  logic                   c2bv_q, c2b_z_q;
  logic [2:0][VecW-1:0]   c2b_v_q;
  logic [2:0][CoordW-1:0] c2b_eye_q;
  logic [2:0][UnitW-1:0]  c2b_dir_q, c2b_right_q;

  logic                   n3_v, n3_z, n3_z0;
  logic [2:0][UnitW-1:0]  n3_upw, n3_dir, n3_right;
  logic [Side3W-1:0]      n3_side;
  logic [2:0][CoordW-1:0] n3_eye;

  logic                        trv_q, tr_deg_q;
  logic [2:0][2:0][VecW-1:0]   tr_p_q;
  logic [2:0][2:0][UnitW-1:0]  tr_ax_q;
  logic                        dtv_q, dt_deg_q;
  logic [2:0][DotW-1:0]        dot_q;
  logic [2:0][2:0][UnitW-1:0]  dt_ax_q;
  logic                        lst_vld_q, lst_deg_q;
  logic [2:0][ShiftW-1:0]      lst_sh_d, lst_sh_q;
  logic [2:0][2:0][UnitW-1:0]  lst_ax_q;

  logic                        ho_vld_q, ho_deg_q;
  logic [2:0][2:0][UnitW-1:0]  ho_ax_q;
  logic [2:0][ShiftW-1:0]      ho_sh_q;
  lav_pkg::axis_e              k_q, k_d;
  logic [2:0][UnitW-1:0]       sel_ax;
  logic [ShiftW-1:0]           sel_sh;

  assign eye_in = {eye_z_i, eye_y_i, eye_x_i};
  assign aim_in = {aim_z_i, aim_y_i, aim_x_i};
  assign up_in  = {up_z_i, up_y_i, up_x_i};

  assign take       = !ho_vld_q || (out_ready_i && (k_q == lav_pkg::AxDir));
  assign en         = !lst_vld_q || take;
  assign load       = lst_vld_q && take;
  assign in_ready_o = en;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      n1_vec[j] = VecW'(signed'(p0_d_q[j]));
    end
  end

  lav_norm #(.SideW(Side1W)) u_norm_dir (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p0v_q),
    .vec_i   (n1_vec),
    .side_i  ({p0_eye_q, p0_up_q}),
    .valid_o (n1_v),
    .unit_o  (n1_dir),
    .zero_o  (n1_z),
    .side_o  (n1_side)
  );

  assign {n1_eye, n1_up} = n1_side;

  lav_norm #(.SideW(Side2W)) u_norm_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c1bv_q),
    .vec_i   (c1b_v_q),
    .side_i  ({c1b_eye_q, c1b_dir_q, c1b_z_q}),
    .valid_o (n2_v),
    .unit_o  (n2_right),
    .zero_o  (n2_z),
    .side_o  (n2_side)
  );

  assign {n2_eye, n2_dir, n2_z1} = n2_side;

  lav_norm #(.SideW(Side3W)) u_norm_upward (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c2bv_q),
    .vec_i   (c2b_v_q),
    .side_i  ({c2b_eye_q, c2b_dir_q, c2b_right_q, c2b_z_q}),
    .valid_o (n3_v),
    .unit_o  (n3_upw),
    .zero_o  (n3_z),
    .side_o  (n3_side)
  );

  assign {n3_eye, n3_dir, n3_right, n3_z0} = n3_side;

  always_comb begin
    logic signed [DotW-1:0] xs;
    for (int k = 0; k < 3; k++) begin
      xs          = signed'((DotW'(1) << (RndPos - 1)) - dot_q[k]);
      lst_sh_d[k] = ShiftW'(xs >>> RndPos);
    end
  end

  always_comb begin
    unique case (k_q)
      lav_pkg::AxRight:  k_d = lav_pkg::AxUpward;
      lav_pkg::AxUpward: k_d = lav_pkg::AxDir;
      default:           k_d = lav_pkg::AxRight;
    endcase
  end

  always_comb begin
    unique case (k_q)
      lav_pkg::AxRight: begin
        sel_ax = ho_ax_q[0];
        sel_sh = ho_sh_q[0];
      end
      lav_pkg::AxUpward: begin
        sel_ax = ho_ax_q[1];
        sel_sh = ho_sh_q[1];
      end
      default: begin
        sel_ax = ho_ax_q[2];
        sel_sh = ho_sh_q[2];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0v_q     <= 1'b0;
      c1av_q    <= 1'b0;
      c1bv_q    <= 1'b0;
      c2av_q    <= 1'b0;
      c2bv_q    <= 1'b0;
      trv_q     <= 1'b0;
      dtv_q     <= 1'b0;
      lst_vld_q <= 1'b0;
    end else if (en) begin
      p0v_q     <= in_valid_i;
      c1av_q    <= n1_v;
      c1bv_q    <= c1av_q;
      c2av_q    <= n2_v;
      c2bv_q    <= c2av_q;
      trv_q     <= n3_v;
      dtv_q     <= trv_q;
      lst_vld_q <= dtv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_eye_q <= eye_in;
      p0_up_q  <= up_in;
      for (int j = 0; j < 3; j++) begin
        p0_d_q[j] <= DiffW'(signed'(aim_in[j])) - DiffW'(signed'(eye_in[j]));
      end

      c1a_p_q   <= cross_prod(n1_up, n1_dir);
      c1a_eye_q <= n1_eye;
      c1a_dir_q <= n1_dir;
      c1a_z_q   <= n1_z;
      for (int j = 0; j < 3; j++) begin
        c1b_v_q[j] <= c1a_p_q[2 * j] - c1a_p_q[2 * j + 1];
      end
      c1b_eye_q <= c1a_eye_q;
      c1b_dir_q <= c1a_dir_q;
      c1b_z_q   <= c1a_z_q;

      c2a_p_q     <= cross_prod(n2_dir, n2_right);
      c2a_eye_q   <= n2_eye;
      c2a_dir_q   <= n2_dir;
      c2a_right_q <= n2_right;
      c2a_z_q     <= n2_z1 | n2_z;
      for (int j = 0; j < 3; j++) begin
        c2b_v_q[j] <= c2a_p_q[2 * j] - c2a_p_q[2 * j + 1];
      end
      c2b_eye_q   <= c2a_eye_q;
      c2b_dir_q   <= c2a_dir_q;
      c2b_right_q <= c2a_right_q;
      c2b_z_q     <= c2a_z_q;

      tr_ax_q  <= {n3_dir, n3_upw, n3_right};
      tr_deg_q <= n3_z0 | n3_z;
      for (int i = 0; i < 3; i++) begin
        tr_p_q[0][i] <= smul(n3_right[i], n3_eye[i]);
        tr_p_q[1][i] <= smul(n3_upw[i], n3_eye[i]);
        tr_p_q[2][i] <= smul(n3_dir[i], n3_eye[i]);
      end

      for (int k = 0; k < 3; k++) begin
        dot_q[k] <= DotW'(signed'(tr_p_q[k][0])) + DotW'(signed'(tr_p_q[k][1]))
                  + DotW'(signed'(tr_p_q[k][2]));
      end
      dt_ax_q  <= tr_ax_q;
      dt_deg_q <= tr_deg_q;

      lst_sh_q  <= lst_sh_d;
      lst_ax_q  <= dt_ax_q;
      lst_deg_q <= dt_deg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ho_vld_q <= 1'b0;
      k_q      <= lav_pkg::AxRight;
    end else if (load) begin
      ho_vld_q <= 1'b1;
      k_q      <= lav_pkg::AxRight;
    end else if (ho_vld_q && out_ready_i) begin
      if (k_q == lav_pkg::AxDir) begin
        ho_vld_q <= 1'b0;
      end
      k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ho_ax_q  <= lst_ax_q;
      ho_sh_q  <= lst_sh_q;
      ho_deg_q <= lst_deg_q;
    end
  end

  assign out_valid_o  = ho_vld_q;
  assign axis_x_o     = ho_deg_q ? '0 : sel_ax[0];
  assign axis_y_o     = ho_deg_q ? '0 : sel_ax[1];
  assign axis_z_o     = ho_deg_q ? '0 : sel_ax[2];
  assign shift_o      = ho_deg_q ? '0 : sel_sh;
  assign axis_index_o = k_q;
  assign last_o       = (k_q == lav_pkg::AxDir);
  assign degenerate_o = ho_deg_q;

  a_stall_needs_backlog : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  a_degenerate_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
      axis_x_o == '0 && axis_y_o == '0 && axis_z_o == '0 && shift_o == '0)
    else $error("degenerate result carries nonzero values");

  a_index_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=>
      out_valid_o && axis_index_o == $past(axis_index_o) + 2'd1)
    else $error("result sequence broken");

  a_unit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !degenerate_o |->
      $signed(axis_x_o) <= 32'sd1073741824 && $signed(axis_x_o) >= -32'sd1073741824 &&
      $signed(axis_y_o) <= 32'sd1073741824 && $signed(axis_y_o) >= -32'sd1073741824 &&
      $signed(axis_z_o) <= 32'sd1073741824 && $signed(axis_z_o) >= -32'sd1073741824)
    else $error("unit component out of range");

endmodule
